// ===== rtl/baw_pkg.sv =====
// Shared types, register indexes and constants of the backward affine warp block.
package baw_pkg;

    // Default store dimensions
    localparam int MAX_ROWS_DEF = 256;
    localparam int MAX_COLS_DEF = 256;

    // Fixed-point format of coordinates and matrix entries
    localparam int FRAC_BITS = 16;
    localparam int COEF_W    = 32;
    localparam int SIZE_CFG_W = 9;
    localparam int PIX_W     = 8;
    localparam int POS_W     = 8;
    // Product of an 8-bit unsigned position and a 32-bit signed weight
    localparam int PROD_W    = COEF_W + POS_W + 1;
    // Sum of two products and an offset, exact
    localparam int SUM_W     = PROD_W + 1;

    // Opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_M_ROW_FROM_ROW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_M_COL_FROM_ROW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_M_ROW_FROM_COL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_M_COL_FROM_COL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_ROW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_COL     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS     = 3'd7;

    // Register reset values
    localparam logic signed [COEF_W-1:0] ONE_Q16  = 32'sd65536;
    localparam logic signed [COEF_W-1:0] ZERO_Q16 = 32'sd0;
    localparam logic [SIZE_CFG_W-1:0]    SIZE_RST = 9'd256;

    // Configuration seen by the coordinate pipeline
    typedef struct packed {
        logic signed [COEF_W-1:0] m_row_from_row;
        logic signed [COEF_W-1:0] m_col_from_row;
        logic signed [COEF_W-1:0] m_row_from_col;
        logic signed [COEF_W-1:0] m_col_from_col;
        logic signed [COEF_W-1:0] offset_row;
        logic signed [COEF_W-1:0] offset_col;
        logic [SIZE_CFG_W-1:0]    image_rows;
        logic [SIZE_CFG_W-1:0]    image_cols;
    } t_warp_cfg;

    // Memory access request
    typedef struct packed {
        logic write;   // store wdata at addr
        logic lookup;  // read addr and return a result beat
        logic hit;     // mapped position lies inside the image
    } t_mem_ctrl;

endpackage

// ===== rtl/baw_addr_pipe.sv =====
// Coordinate pipeline: affine products, sums, bound test and memory address.
module baw_addr_pipe #(
    parameter int MAX_ROWS = baw_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = baw_pkg::MAX_COLS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_load,
    input  logic                                i_opcode,
    input  logic [baw_pkg::POS_W-1:0]           i_row,
    input  logic [baw_pkg::POS_W-1:0]           i_col,
    input  logic [baw_pkg::PIX_W-1:0]           i_pixel_in,
    input  baw_pkg::t_warp_cfg                  i_cfg,
    output logic                                o_req_valid,
    output baw_pkg::t_mem_ctrl                  o_req,
    output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] o_addr,
    output logic [baw_pkg::PIX_W-1:0]           o_wdata
);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_XW = (ROW_W > baw_pkg::POS_W) ? ROW_W : baw_pkg::POS_W;
    localparam int COL_XW = (COL_W > baw_pkg::POS_W) ? COL_W : baw_pkg::POS_W;
    localparam int RSZ_W  = ($clog2(MAX_ROWS + 1) > baw_pkg::SIZE_CFG_W) ?
                            $clog2(MAX_ROWS + 1) : baw_pkg::SIZE_CFG_W;
    localparam int CSZ_W  = ($clog2(MAX_COLS + 1) > baw_pkg::SIZE_CFG_W) ?
                            $clog2(MAX_COLS + 1) : baw_pkg::SIZE_CFG_W;
    localparam int FB     = baw_pkg::FRAC_BITS;
    localparam int PW     = baw_pkg::PROD_W;
    localparam int SW     = baw_pkg::SUM_W;

    // Stage 1: products
    logic                         r_s1_valid;
    logic                         r_s1_op;
    logic [baw_pkg::POS_W-1:0]    r_s1_row;
    logic [baw_pkg::POS_W-1:0]    r_s1_col;
    logic [baw_pkg::PIX_W-1:0]    r_s1_pix;
    logic signed [PW-1:0]         r_p_rr;
    logic signed [PW-1:0]         r_p_rc;
    logic signed [PW-1:0]         r_p_cr;
    logic signed [PW-1:0]         r_p_cc;

    // Stage 2: sums
    logic                         r_s2_valid;
    logic                         r_s2_op;
    logic [baw_pkg::POS_W-1:0]    r_s2_row;
    logic [baw_pkg::POS_W-1:0]    r_s2_col;
    logic [baw_pkg::PIX_W-1:0]    r_s2_pix;
    logic signed [SW-1:0]         r_sr;
    logic signed [SW-1:0]         r_sc;

    // Stage 3: request
    logic                         r_s3_valid;
    baw_pkg::t_mem_ctrl           r_s3_ctrl;
    logic [ROW_W+COL_W-1:0]       r_s3_addr;
    logic [baw_pkg::PIX_W-1:0]    r_s3_wdata;

    logic [RSZ_W-1:0]             rows_use;
    logic [CSZ_W-1:0]             cols_use;
    logic signed [SW-1:0]         row_lim;
    logic signed [SW-1:0]         col_lim;
    logic                         n_hit;
    logic [ROW_XW-1:0]            wr_row_x;
    logic [COL_XW-1:0]            wr_col_x;
    logic                         wr_in_range;
    baw_pkg::t_mem_ctrl           n_ctrl;
    logic [ROW_W+COL_W-1:0]       n_addr;

    // Valid bits of the three stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (i_en) begin
            r_s1_valid <= i_load;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    // Form the four products of position and weight
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_op  <= i_opcode;
            r_s1_row <= i_row;
            r_s1_col <= i_col;
            r_s1_pix <= i_pixel_in;
            r_p_rr   <= $signed({1'b0, i_row}) * i_cfg.m_row_from_row;
            r_p_rc   <= $signed({1'b0, i_col}) * i_cfg.m_row_from_col;
            r_p_cr   <= $signed({1'b0, i_row}) * i_cfg.m_col_from_row;
            r_p_cc   <= $signed({1'b0, i_col}) * i_cfg.m_col_from_col;
        end
    end

    // Add products and offsets into exact source coordinates
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_op  <= r_s1_op;
            r_s2_row <= r_s1_row;
            r_s2_col <= r_s1_col;
            r_s2_pix <= r_s1_pix;
            r_sr     <= SW'(r_p_rr) + SW'(r_p_rc) + SW'(i_cfg.offset_row);
            r_sc     <= SW'(r_p_cr) + SW'(r_p_cc) + SW'(i_cfg.offset_col);
        end
    end

    // Clamp sizes to the store and scale them to Q16
    always_comb begin
        rows_use = (RSZ_W'(i_cfg.image_rows) > RSZ_W'(MAX_ROWS)) ?
                   RSZ_W'(MAX_ROWS) : RSZ_W'(i_cfg.image_rows);
        cols_use = (CSZ_W'(i_cfg.image_cols) > CSZ_W'(MAX_COLS)) ?
                   CSZ_W'(MAX_COLS) : CSZ_W'(i_cfg.image_cols);
        row_lim  = $signed({{(SW-RSZ_W-FB){1'b0}}, rows_use, {FB{1'b0}}});
        col_lim  = $signed({{(SW-CSZ_W-FB){1'b0}}, cols_use, {FB{1'b0}}});
    end

    // Strict bound test, write range check and address select
    always_comb begin
        n_hit       = (r_sr > $signed(SW'(0))) && (r_sr < row_lim) &&
                      (r_sc > $signed(SW'(0))) && (r_sc < col_lim);
        wr_row_x    = ROW_XW'(r_s2_row);
        wr_col_x    = COL_XW'(r_s2_col);
        wr_in_range = (32'(r_s2_row) < 32'(MAX_ROWS)) &&
                      (32'(r_s2_col) < 32'(MAX_COLS));
        n_ctrl.write  = (r_s2_op == baw_pkg::OP_WRITE) && wr_in_range;
        n_ctrl.lookup = (r_s2_op == baw_pkg::OP_LOOKUP);
        n_ctrl.hit    = n_hit;
        if (r_s2_op == baw_pkg::OP_WRITE) begin
            n_addr = {wr_row_x[ROW_W-1:0], wr_col_x[COL_W-1:0]};
        end else begin
            n_addr = {r_sr[FB+ROW_W-1:FB], r_sc[FB+COL_W-1:FB]};
        end
    end

    // Register the memory request
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s3_ctrl  <= n_ctrl;
            r_s3_addr  <= n_addr;
            r_s3_wdata <= r_s2_pix;
        end
    end

    assign o_req_valid = r_s3_valid;
    assign o_req       = r_s3_ctrl;
    assign o_addr      = r_s3_addr;
    assign o_wdata     = r_s3_wdata;

endmodule

// ===== rtl/baw_image_mem.sv =====
// Source image store: single-port synchronous RAM with registered read and result stage.
module baw_image_mem #(
    parameter int MAX_ROWS = baw_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = baw_pkg::MAX_COLS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_req_valid,
    input  baw_pkg::t_mem_ctrl                  i_req,
    input  logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] i_addr,
    input  logic [baw_pkg::PIX_W-1:0]           i_wdata,
    output logic                                o_valid,
    output logic                                o_hit,
    output logic [baw_pkg::PIX_W-1:0]           o_pixel
);
    localparam int AW    = $clog2(MAX_ROWS) + $clog2(MAX_COLS);
    localparam int DEPTH = 1 << AW;

    logic [baw_pkg::PIX_W-1:0] r_mem [DEPTH];
    logic [baw_pkg::PIX_W-1:0] r_rd_data;
    logic                      r_valid;
    logic                      r_hit;

    // Write a pixel beat or read the mapped entry, one access per cycle while enabled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_req_valid && i_req.write) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rd_data <= r_mem[i_addr];
        end
    end

    // Result stage: only lookups produce a beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_req_valid && i_req.lookup;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= i_req.hit;
        end
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;
    assign o_pixel = r_hit ? r_rd_data : '0;

endmodule

// ===== rtl/backward_affine_image_warp.sv =====
// Top level: configuration registers, handshake control and the warp pipeline.
// A lookup passes the product, sum and request stages and the RAM read stage before its result beat is valid.
// Throughput: one input beat per cycle; the single RAM port serves one write or one
// lookup per cycle and the pipeline holds as a whole only while the result waits.
// Writes produce no result beat. Reset is synchronous, active low: it clears the stage
// valid bits and loads the identity map with a full-size image; the store is not cleared.
module backward_affine_image_warp #(
    parameter int MAX_ROWS = baw_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = baw_pkg::MAX_COLS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [baw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [baw_pkg::COEF_W-1:0]        i_cfg_data,
    // Input channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_opcode,
    input  logic [baw_pkg::POS_W-1:0]         i_row,
    input  logic [baw_pkg::POS_W-1:0]         i_col,
    input  logic [baw_pkg::PIX_W-1:0]         i_pixel_in,
    // Result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_hit,
    output logic [baw_pkg::PIX_W-1:0]         o_pixel_out
);
    localparam int AW = $clog2(MAX_ROWS) + $clog2(MAX_COLS);

    baw_pkg::t_warp_cfg         r_cfg;
    logic                       pipe_en;
    logic                       req_valid;
    baw_pkg::t_mem_ctrl         req;
    logic [AW-1:0]              req_addr;
    logic [baw_pkg::PIX_W-1:0]  req_wdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.m_row_from_row <= baw_pkg::ONE_Q16;
            r_cfg.m_col_from_row <= baw_pkg::ZERO_Q16;
            r_cfg.m_row_from_col <= baw_pkg::ZERO_Q16;
            r_cfg.m_col_from_col <= baw_pkg::ONE_Q16;
            r_cfg.offset_row     <= baw_pkg::ZERO_Q16;
            r_cfg.offset_col     <= baw_pkg::ZERO_Q16;
            r_cfg.image_rows     <= baw_pkg::SIZE_RST;
            r_cfg.image_cols     <= baw_pkg::SIZE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                baw_pkg::CFG_M_ROW_FROM_ROW: r_cfg.m_row_from_row <= $signed(i_cfg_data);
                baw_pkg::CFG_M_COL_FROM_ROW: r_cfg.m_col_from_row <= $signed(i_cfg_data);
                baw_pkg::CFG_M_ROW_FROM_COL: r_cfg.m_row_from_col <= $signed(i_cfg_data);
                baw_pkg::CFG_M_COL_FROM_COL: r_cfg.m_col_from_col <= $signed(i_cfg_data);
                baw_pkg::CFG_OFFSET_ROW:     r_cfg.offset_row     <= $signed(i_cfg_data);
                baw_pkg::CFG_OFFSET_COL:     r_cfg.offset_col     <= $signed(i_cfg_data);
                baw_pkg::CFG_IMAGE_ROWS:
                    r_cfg.image_rows <= i_cfg_data[baw_pkg::SIZE_CFG_W-1:0];
                baw_pkg::CFG_IMAGE_COLS:
                    r_cfg.image_cols <= i_cfg_data[baw_pkg::SIZE_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Advance the whole pipeline unless a result beat is stalled
    assign pipe_en    = !o_out_valid || i_out_ready;
    assign o_in_ready = pipe_en;

    baw_addr_pipe #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_addr_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (pipe_en),
        .i_load      (i_in_valid),
        .i_opcode    (i_opcode),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_pixel_in  (i_pixel_in),
        .i_cfg       (r_cfg),
        .o_req_valid (req_valid),
        .o_req       (req),
        .o_addr      (req_addr),
        .o_wdata     (req_wdata)
    );

    baw_image_mem #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_image_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (pipe_en),
        .i_req_valid (req_valid),
        .i_req       (req),
        .i_addr      (req_addr),
        .i_wdata     (req_wdata),
        .o_valid     (o_out_valid),
        .o_hit       (o_hit),
        .o_pixel     (o_pixel_out)
    );

endmodule

// ===== sim/backward_affine_image_warp_tb.sv =====
// Self-checking testbench for backward_affine_image_warp: directed and random pixel traffic.
module backward_affine_image_warp_tb;

    // Expected lookup result beat
    typedef struct packed {
        logic                      hit;
        logic [baw_pkg::PIX_W-1:0] pixel;
    } t_warp_pixel;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [baw_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [baw_pkg::COEF_W-1:0]    cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic                          opcode = baw_pkg::OP_WRITE;
    logic [baw_pkg::POS_W-1:0]     row = '0;
    logic [baw_pkg::POS_W-1:0]     col = '0;
    logic [baw_pkg::PIX_W-1:0]     pixel_in = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          hit;
    logic [baw_pkg::PIX_W-1:0]     pixel_out;

    // Shadow of the block: matrix, sizes and the source image
    baw_pkg::t_warp_cfg            warp_cfg;
    logic [baw_pkg::PIX_W-1:0]     src_image [65536];
    bit                            src_written [65536];
    t_warp_pixel                   pixels_due [$];

    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   mismatches = 0;
    int                   items_sent = 0;

    backward_affine_image_warp uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_opcode    (opcode),
        .i_row       (row),
        .i_col       (col),
        .i_pixel_in  (pixel_in),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_hit       (hit),
        .o_pixel_out (pixel_out)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the result channel at random
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare each result beat with the oldest pending lookup
    always @(posedge clk) begin
        t_warp_pixel due;
        if (rst_n && out_valid && out_ready) begin
            if (pixels_due.size() == 0) begin
                $error("result beat with no lookup pending: hit %0d pixel_out %0d",
                       hit, pixel_out);
                mismatches++;
            end else begin
                due = pixels_due.pop_front();
                if (hit !== due.hit) begin
                    $error("hit: expected %0d, got %0d", due.hit, hit);
                    mismatches++;
                end
                if (pixel_out !== due.pixel) begin
                    $error("pixel_out: expected %0d, got %0d", due.pixel, pixel_out);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("backward_affine_image_warp_tb: errors");
        $finish;
    end

    function automatic baw_pkg::t_warp_cfg make_cfg(input int rr, input int cr,
                                                    input int rc, input int cc,
                                                    input int off_r, input int off_c,
                                                    input int rows, input int cols);
        baw_pkg::t_warp_cfg cfg;
        cfg.m_row_from_row = rr;
        cfg.m_col_from_row = cr;
        cfg.m_row_from_col = rc;
        cfg.m_col_from_col = cc;
        cfg.offset_row     = off_r;
        cfg.offset_col     = off_c;
        cfg.image_rows     = baw_pkg::SIZE_CFG_W'(rows);
        cfg.image_cols     = baw_pkg::SIZE_CFG_W'(cols);
        return cfg;
    endfunction

    // Map an output position to the source image; return 1 on a hit
    function automatic logic map_to_source(input logic [baw_pkg::POS_W-1:0] r,
                                           input logic [baw_pkg::POS_W-1:0] c,
                                           output logic [15:0] src);
        longint src_row, src_col, row_lim, col_lim;
        src_row = longint'(r) * longint'($signed(warp_cfg.m_row_from_row))
                + longint'(c) * longint'($signed(warp_cfg.m_row_from_col))
                + longint'($signed(warp_cfg.offset_row));
        src_col = longint'(r) * longint'($signed(warp_cfg.m_col_from_row))
                + longint'(c) * longint'($signed(warp_cfg.m_col_from_col))
                + longint'($signed(warp_cfg.offset_col));
        // Sizes above the store act as the store size
        row_lim = longint'((warp_cfg.image_rows > baw_pkg::MAX_ROWS_DEF) ?
                           baw_pkg::MAX_ROWS_DEF : warp_cfg.image_rows);
        col_lim = longint'((warp_cfg.image_cols > baw_pkg::MAX_COLS_DEF) ?
                           baw_pkg::MAX_COLS_DEF : warp_cfg.image_cols);
        row_lim = row_lim << baw_pkg::FRAC_BITS;
        col_lim = col_lim << baw_pkg::FRAC_BITS;
        src = {src_row[23:16], src_col[23:16]};
        return src_row > 0 && src_row < row_lim && src_col > 0 && src_col < col_lim;
    endfunction

    // Drive one input beat, hold it until accepted, then update the shadow
    task automatic send_item(input logic op, input logic [baw_pkg::POS_W-1:0] r,
                             input logic [baw_pkg::POS_W-1:0] c,
                             input logic [baw_pkg::PIX_W-1:0] p);
        t_warp_pixel due;
        logic [15:0] src;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        row      <= r;
        col      <= c;
        pixel_in <= p;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (op == baw_pkg::OP_WRITE) begin
            src_image[{r, c}]   = p;
            src_written[{r, c}] = 1'b1;
        end else begin
            due.hit   = map_to_source(r, c, src);
            due.pixel = due.hit ? src_image[src] : '0;
            pixels_due.push_back(due);
        end
    endtask

    // Look up a position; store a pixel first where the hit lands on an empty location
    task automatic lookup_pixel(input logic [baw_pkg::POS_W-1:0] r,
                                input logic [baw_pkg::POS_W-1:0] c);
        logic [15:0] src;
        if (map_to_source(r, c, src) && !src_written[src])
            send_item(baw_pkg::OP_WRITE, src[15:8], src[7:0], baw_pkg::PIX_W'($urandom));
        send_item(baw_pkg::OP_LOOKUP, r, c, baw_pkg::PIX_W'($urandom));
    endtask

    // Drop valid, wait for every pending result, then let the pipeline empty
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pixels_due.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write all eight registers; call only while idle
    task automatic load_warp(input baw_pkg::t_warp_cfg cfg);
        logic [baw_pkg::COEF_W-1:0] value [8];
        value[baw_pkg::CFG_M_ROW_FROM_ROW] = cfg.m_row_from_row;
        value[baw_pkg::CFG_M_COL_FROM_ROW] = cfg.m_col_from_row;
        value[baw_pkg::CFG_M_ROW_FROM_COL] = cfg.m_row_from_col;
        value[baw_pkg::CFG_M_COL_FROM_COL] = cfg.m_col_from_col;
        value[baw_pkg::CFG_OFFSET_ROW]     = cfg.offset_row;
        value[baw_pkg::CFG_OFFSET_COL]     = cfg.offset_col;
        value[baw_pkg::CFG_IMAGE_ROWS]     = baw_pkg::COEF_W'(cfg.image_rows);
        value[baw_pkg::CFG_IMAGE_COLS]     = baw_pkg::COEF_W'(cfg.image_cols);
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= baw_pkg::CFG_IDX_W'(i);
            cfg_data  <= value[i];
            @(posedge clk);
        end
        cfg_we   <= 1'b0;
        warp_cfg = cfg;
    endtask

    // Mostly near-identity maps with random sizes, now and then a wild matrix
    function automatic baw_pkg::t_warp_cfg random_warp();
        int rr, cc, rows, cols, pick;
        pick = $urandom_range(99);
        rows = (pick < 5) ? 0 : (pick < 15) ? $urandom_range(257, 511) : $urandom_range(1, 256);
        pick = $urandom_range(99);
        cols = (pick < 5) ? 0 : (pick < 15) ? $urandom_range(257, 511) : $urandom_range(1, 256);
        if ($urandom_range(7) == 0)
            return make_cfg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                            rows, cols);
        rr = $urandom_range(32768, 131072);
        cc = $urandom_range(32768, 131072);
        if ($urandom_range(3) == 0) rr = -rr;
        if ($urandom_range(3) == 0) cc = -cc;
        return make_cfg(rr, int'($urandom_range(65536)) - 32768,
                        int'($urandom_range(65536)) - 32768, cc,
                        int'($urandom_range(1 << 24)) - (1 << 23),
                        int'($urandom_range(1 << 24)) - (1 << 23), rows, cols);
    endfunction

    // Identity map from reset: corners, zero coordinates, write then read back
    task automatic test_reset_map();
        send_item(baw_pkg::OP_WRITE, 8'd1, 8'd1, 8'hFF);
        send_item(baw_pkg::OP_WRITE, 8'd255, 8'd255, 8'h00);
        lookup_pixel(8'd1, 8'd1);
        lookup_pixel(8'd255, 8'd255);
        lookup_pixel(8'd0, 8'd0);
        lookup_pixel(8'd0, 8'd7);
        lookup_pixel(8'd7, 8'd0);
        send_item(baw_pkg::OP_WRITE, 8'd1, 8'd1, 8'hA5);
        lookup_pixel(8'd1, 8'd1);
    endtask

    // Coordinates on the image edge, sizes above the store and sizes of zero
    task automatic test_image_bounds();
        wait_idle();
        load_warp(make_cfg(baw_pkg::ONE_Q16, baw_pkg::ZERO_Q16, baw_pkg::ZERO_Q16,
                           baw_pkg::ONE_Q16, 0, 0, 10, 20));
        lookup_pixel(8'd9, 8'd19);
        lookup_pixel(8'd10, 8'd3);
        lookup_pixel(8'd3, 8'd20);
        wait_idle();
        load_warp(make_cfg(baw_pkg::ONE_Q16, baw_pkg::ZERO_Q16, baw_pkg::ZERO_Q16,
                           baw_pkg::ONE_Q16, 0, 0, 511, 257));
        lookup_pixel(8'd255, 8'd255);
        lookup_pixel(8'd200, 8'd3);
        wait_idle();
        load_warp(make_cfg(baw_pkg::ONE_Q16, baw_pkg::ZERO_Q16, baw_pkg::ZERO_Q16,
                           baw_pkg::ONE_Q16, 0, 0, 0, 0));
        lookup_pixel(8'd5, 8'd5);
    endtask

    // Extreme weights and offsets, fractional truncation and a mirrored map
    task automatic test_matrix_extremes();
        wait_idle();
        load_warp(make_cfg(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h8000_0000, 256, 256));
        lookup_pixel(8'd255, 8'd255);
        lookup_pixel(8'd0, 8'd0);
        lookup_pixel(8'd128, 8'd1);
        wait_idle();
        load_warp(make_cfg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 256, 256));
        lookup_pixel(8'd0, 8'd0);
        lookup_pixel(8'd1, 8'd0);
        wait_idle();
        load_warp(make_cfg(baw_pkg::ZERO_Q16, baw_pkg::ZERO_Q16, baw_pkg::ZERO_Q16,
                           baw_pkg::ZERO_Q16, 32'h0000_8000, 32'h0003_4000, 256, 256));
        lookup_pixel(8'd0, 8'd0);
        lookup_pixel(8'd255, 8'd255);
        wait_idle();
        load_warp(make_cfg(-65536, baw_pkg::ZERO_Q16, baw_pkg::ZERO_Q16, -65536,
                           32'h00FF_8000, 32'h00FF_8000, 256, 256));
        lookup_pixel(8'd0, 8'd0);
        lookup_pixel(8'd255, 8'd255);
    endtask

    // Random writes and lookups under a fresh random map every chunk
    task automatic test_random_traffic(input int items, input int idle_pct,
                                       input int stall_pct);
        int start;
        start          = items_sent;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (items_sent - start < items) begin
            wait_idle();
            load_warp(random_warp());
            for (int k = 0; k < 145 && items_sent - start < items; k++) begin
                if ($urandom_range(99) < 35)
                    send_item(baw_pkg::OP_WRITE, baw_pkg::POS_W'($urandom),
                              baw_pkg::POS_W'($urandom), baw_pkg::PIX_W'($urandom));
                else
                    lookup_pixel(baw_pkg::POS_W'($urandom), baw_pkg::POS_W'($urandom));
            end
        end
    endtask

    initial begin
        warp_cfg = make_cfg(baw_pkg::ONE_Q16, baw_pkg::ZERO_Q16, baw_pkg::ZERO_Q16,
                            baw_pkg::ONE_Q16, baw_pkg::ZERO_Q16, baw_pkg::ZERO_Q16,
                            baw_pkg::SIZE_RST, baw_pkg::SIZE_RST);
        repeat (3) @(posedge clk);
        rst_n          <= 1'b1;
        send_idle_pct  = 11;
        recv_stall_pct = 50;
        test_reset_map();
        test_image_bounds();
        test_matrix_extremes();
        test_random_traffic(580, 11, 50);
        test_random_traffic(580, 50, 11);
        test_random_traffic(590, 0, 0);
        wait_idle();
        if (mismatches == 0)
            $display("backward_affine_image_warp_tb: clean");
        else
            $display("backward_affine_image_warp_tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/baw_pkg.sv
rtl/baw_addr_pipe.sv
rtl/baw_image_mem.sv
rtl/backward_affine_image_warp.sv
sim/backward_affine_image_warp_tb.sv
